// ----- sv/height_map_tilt_remap_defines.svh -----
// assertion macros for the tilt remap block
`ifndef HEIGHT_MAP_TILT_REMAP_DEFINES_SVH
`define HEIGHT_MAP_TILT_REMAP_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle
`define HMTR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hmtr check failed");
// condition holds in the next cycle
`define HMTR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hmtr check failed");
`else
`define HMTR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define HMTR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/hmtr_pkg.sv -----
`timescale 1ns / 1ps
package hmtr_pkg;

    localparam int unsigned DEF_MAX_DIM     = 256;
    localparam int unsigned DEF_HEIGHT_BITS = 32;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes
    localparam logic [2:0] CFG_ROW_COUNT  = 3'd0;
    localparam logic [2:0] CFG_COL_COUNT  = 3'd1;
    localparam logic [2:0] CFG_COS_ANGLE  = 3'd2;
    localparam logic [2:0] CFG_SIN_ANGLE  = 3'd3;
    localparam logic [2:0] CFG_UNASSIGNED = 3'd4;

    // 8-bit value modulo a constant, by compare and subtract
    function automatic logic [7:0] mod_dim(input logic [7:0] v, input int unsigned m);
        logic [31:0] x;
        x = {24'b0, v};
        for (int k = 7; k >= 0; k--) begin
            if (((m << k) <= 32'd255) && (x >= (m << k))) begin
                x = x - (m << k);
            end
        end
        return x[7:0];
    endfunction

endpackage

// ----- sv/height_map_tilt_remap.sv -----
`timescale 1ns / 1ps
// load: taken back to back in idle; read: registered store read, then result register,
// no request while a read pends or m_valid waits on m_ready; run after the last load:
// sweep of all 2^(2*clog2(MAX_DIM)) store entries, mean divider, then rows*cols walk
// the sweep (one store entry a cycle) and the single source read port set the run length
// reset (aresetn low, synchronous) clears control and runs the same sweep over the tilted
// store, with no requests taken; config writes still taken
`include "height_map_tilt_remap_defines.svh"

module height_map_tilt_remap
    import hmtr_pkg::*;
#(
    parameter int unsigned MAX_DIM     = DEF_MAX_DIM,
    parameter int unsigned HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [HEIGHT_BITS-1:0] s_height,
    input  logic [7:0]                    s_contrast,
    input  logic                          s_last,
    input  logic [7:0]                    s_read_row,
    input  logic [7:0]                    s_read_col,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [HEIGHT_BITS-1:0] m_tilted_height,
    output logic [7:0]                    m_tilted_contrast,
    output logic signed [HEIGHT_BITS-1:0] m_height_above_min,
    output logic                          m_assigned,
    output logic [7:0]                    m_source_row,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int unsigned HB    = HEIGHT_BITS;
    localparam int unsigned IW    = $clog2(MAX_DIM);
    localparam int unsigned CW    = $clog2(MAX_DIM + 1);
    localparam int unsigned AW    = 2 * IW;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned NCW   = 2 * CW;
    localparam int unsigned SUMW  = HB + NCW;
    localparam int unsigned NW    = SUMW + 2;
    localparam int unsigned RLW   = NW + 2;
    localparam int unsigned YW    = CW + 17;
    localparam int unsigned PAW   = YW + 16;
    localparam int unsigned PBW   = HB + 16;
    localparam int unsigned ACCW  = ((PAW > PBW) ? PAW : PBW) + 2;
    localparam int unsigned NRW   = ACCW - 31;
    localparam int unsigned DCW   = $clog2(NW + 1);
    localparam int unsigned SW    = HB + 8;
    localparam int unsigned TW    = 2 * HB + 17;

    // phase codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_TAIL  = 3'd2;
    localparam logic [2:0] ST_DINIT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_MEAN  = 3'd5;
    localparam logic [2:0] ST_WALK  = 3'd6;

    // configuration registers
    logic [8:0]         row_count_reg, col_count_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [31:0] unassigned_reg;
    logic [CW-1:0]      rows_c, cols_c;
    logic [NCW-1:0]     n_cur;

    logic [2:0]  state_reg, state_next;
    logic        run_reg;

    // load side
    logic [NCW-1:0] lc_reg;
    logic [IW-1:0]  ld_row_reg, ld_col_reg;
    logic           s_acc, ld_acc, rd_acc, ld_we;

    // source store
    logic [SW-1:0]  src_mem [DEPTH];
    logic [SW-1:0]  src_q_reg;
    logic [AW-1:0]  src_raddr;
    logic signed [HB-1:0] src_h;
    logic [7:0]     src_c;

    // tilted store
    logic [TW-1:0]  tlt_mem [DEPTH];
    logic [TW-1:0]  tlt_q_reg;
    logic           t_we;
    logic [AW-1:0]  t_waddr, t_raddr;
    logic [TW-1:0]  t_wdata;

    // sweep and statistics
    logic [AW-1:0]  sw_addr_reg;
    logic           sw_rdv_reg, sw_img_reg, first_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [HB-1:0]   min_reg;
    logic [NCW-1:0] n_reg;
    logic signed [HB-1:0]   clear_h_reg;

    // mean divider
    logic [NW-1:0]  quo_reg;
    logic [NCW:0]   rem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           neg_reg;
    logic signed [NW-1:0] num;
    logic [NCW+1:0] rem_sh, dvs;
    logic           ge;
    logic signed [NW:0] mean_reg, q_ext;

    // walk pipeline
    logic           wk_act_reg;
    logic [IW-1:0]  wk_row_reg, wk_col_reg;
    logic           p1_v_reg, p2_v_reg, p3_v_reg;
    logic           p1_f_reg, p2_f_reg, p3_f_reg;
    logic [IW-1:0]  p1_r_reg, p2_r_reg, p3_r_reg;
    logic [IW-1:0]  p1_c_reg, p2_c_reg, p3_c_reg;
    logic [7:0]     p2_ct_reg, p3_ct_reg;
    logic signed [HB:0]    p2_diff_reg;
    logic signed [RLW-1:0] p2_rel_reg;
    logic signed [HB:0]    diff_w;
    logic signed [HB-1:0]  rel_s, amin_s, p3_rel_reg, p3_amin_reg;
    logic signed [YW-1:0]  yc;
    logic signed [PAW-1:0] p3_pa_reg;
    logic signed [PBW-1:0] p3_pb_reg;
    logic signed [ACCW-1:0] acc;
    logic signed [NRW-1:0]  nr, prev_row;
    logic signed [CW:0]     lwr_reg;
    logic           wk_ok;

    // read side
    logic           rd_pend_reg, m_valid_reg;
    logic signed [HB-1:0] o_th_reg, o_am_reg;
    logic [7:0]     o_tc_reg, o_sr_reg;
    logic           o_as_reg;

    // clamp row and column counts
    always_comb begin
        if (row_count_reg == 9'd0) begin
            rows_c = CW'(1);
        end else if (32'(row_count_reg) > MAX_DIM) begin
            rows_c = CW'(MAX_DIM);
        end else begin
            rows_c = CW'(row_count_reg);
        end
        if (col_count_reg == 9'd0) begin
            cols_c = CW'(1);
        end else if (32'(col_count_reg) > MAX_DIM) begin
            cols_c = CW'(MAX_DIM);
        end else begin
            cols_c = CW'(col_count_reg);
        end
    end
    assign n_cur = NCW'(rows_c) * NCW'(cols_c);

    // config write port
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= 9'(MAX_DIM);
            col_count_reg  <= 9'(MAX_DIM);
            cos_reg        <= 16'sd32767;
            sin_reg        <= '0;
            unassigned_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data[8:0];
                CFG_COL_COUNT:  col_count_reg  <= cfg_data[8:0];
                CFG_COS_ANGLE:  cos_reg        <= cfg_data[15:0];
                CFG_SIN_ANGLE:  sin_reg        <= cfg_data[15:0];
                CFG_UNASSIGNED: unassigned_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request handshake
    assign s_ready = (state_reg == ST_IDLE) && !rd_pend_reg && (!m_valid_reg || m_ready);
    assign s_acc   = s_valid && s_ready;
    assign ld_acc  = s_acc && (s_op == OP_LOAD);
    assign rd_acc  = s_acc && (s_op == OP_READ);
    assign ld_we   = ld_acc && (lc_reg < n_cur);

    // phase sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (ld_acc && s_last) state_next = ST_SWEEP;
            ST_SWEEP: if (sw_addr_reg == AW'(DEPTH - 1)) state_next = ST_TAIL;
            ST_TAIL:  state_next = run_reg ? ST_DINIT : ST_IDLE;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:   if (dcnt_reg == DCW'(1)) state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_WALK;
            ST_WALK:  if (!wk_act_reg && !p1_v_reg && !p2_v_reg && !p3_v_reg) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            run_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && state_next == ST_SWEEP) begin
                run_reg <= 1'b1;
            end
        end
    end

    // load position in raster order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg     <= '0;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end else if (ld_acc && s_last) begin
            lc_reg     <= '0;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end else if (ld_we) begin
            lc_reg <= lc_reg + NCW'(1);
            if (CW'(ld_col_reg) == cols_c - CW'(1)) begin
                ld_col_reg <= '0;
                ld_row_reg <= ld_row_reg + IW'(1);
            end else begin
                ld_col_reg <= ld_col_reg + IW'(1);
            end
        end
    end

    // source store, one write and one read port
    assign src_raddr = (state_reg == ST_WALK) ? {wk_row_reg, wk_col_reg} : sw_addr_reg;
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            src_mem[{ld_row_reg, ld_col_reg}] <= {s_contrast, s_height};
        end
        src_q_reg <= src_mem[src_raddr];
    end
    assign src_h = src_q_reg[HB-1:0];
    assign src_c = src_q_reg[SW-1:HB];

    // sweep: clear tilted store, gather sum and minimum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_addr_reg <= '0;
            sw_rdv_reg  <= 1'b0;
            sw_img_reg  <= 1'b0;
            first_reg   <= 1'b1;
            sum_reg     <= '0;
            min_reg     <= '0;
            n_reg       <= '0;
            clear_h_reg <= '0;
        end else begin
            sw_rdv_reg <= (state_reg == ST_SWEEP);
            sw_img_reg <= (CW'(sw_addr_reg[AW-1:IW]) < rows_c) &&
                          (CW'(sw_addr_reg[IW-1:0]) < cols_c);
            if (state_reg == ST_IDLE && state_next == ST_SWEEP) begin
                sw_addr_reg <= '0;
                first_reg   <= 1'b1;
                sum_reg     <= '0;
                n_reg       <= n_cur;
                clear_h_reg <= HB'(unassigned_reg);
            end else if (state_reg == ST_SWEEP) begin
                sw_addr_reg <= sw_addr_reg + AW'(1);
            end
            if (run_reg && sw_rdv_reg && sw_img_reg) begin
                sum_reg   <= sum_reg + SUMW'(src_h);
                first_reg <= 1'b0;
                if (first_reg || (src_h < min_reg)) begin
                    min_reg <= src_h;
                end
            end
        end
    end

    // mean = floor((2*sum + n) / (2*n)), restoring divide on magnitudes
    assign num    = $signed({sum_reg[SUMW-1], sum_reg, 1'b0}) + NW'($signed({1'b0, n_reg}));
    assign dvs    = {1'b0, n_reg, 1'b0};
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign ge     = rem_sh >= dvs;
    assign q_ext  = $signed({1'b0, quo_reg});
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
            neg_reg  <= 1'b0;
            mean_reg <= '0;
        end else begin
            case (state_reg)
                ST_DINIT: begin
                    neg_reg  <= num[NW-1];
                    quo_reg  <= num[NW-1] ? NW'(-num) : NW'(num);
                    rem_reg  <= '0;
                    dcnt_reg <= DCW'(NW);
                end
                ST_DIV: begin
                    quo_reg  <= {quo_reg[NW-2:0], ge};
                    rem_reg  <= ge ? (NCW+1)'(rem_sh - dvs) : rem_sh[NCW:0];
                    dcnt_reg <= dcnt_reg - DCW'(1);
                end
                ST_MEAN: begin
                    if (neg_reg) begin
                        mean_reg <= -(q_ext + (NW+1)'(rem_reg != '0));
                    end else begin
                        mean_reg <= q_ext;
                    end
                end
                default: ;
            endcase
        end
    end

    // walk issue: columns outer, rows top to bottom
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wk_act_reg <= 1'b0;
            wk_row_reg <= '0;
            wk_col_reg <= '0;
        end else if (state_reg == ST_MEAN) begin
            wk_act_reg <= 1'b1;
            wk_row_reg <= '0;
            wk_col_reg <= '0;
        end else if (state_reg == ST_WALK && wk_act_reg) begin
            if (CW'(wk_row_reg) == rows_c - CW'(1)) begin
                wk_row_reg <= '0;
                if (CW'(wk_col_reg) == cols_c - CW'(1)) begin
                    wk_act_reg <= 1'b0;
                end else begin
                    wk_col_reg <= wk_col_reg + IW'(1);
                end
            end else begin
                wk_row_reg <= wk_row_reg + IW'(1);
            end
        end
    end

    // stage 1 -> 2: height minus minimum, minus mean
    assign diff_w = (HB+1)'(src_h) - (HB+1)'(min_reg);

    // stage 2 -> 3: saturate, centered row, products
    always_comb begin
        if (p2_rel_reg[RLW-1:HB-1] == '0 || p2_rel_reg[RLW-1:HB-1] == '1) begin
            rel_s = p2_rel_reg[HB-1:0];
        end else begin
            rel_s = {p2_rel_reg[RLW-1], {(HB-1){~p2_rel_reg[RLW-1]}}};
        end
        if (p2_diff_reg[HB] == p2_diff_reg[HB-1]) begin
            amin_s = p2_diff_reg[HB-1:0];
        end else begin
            amin_s = {p2_diff_reg[HB], {(HB-1){~p2_diff_reg[HB]}}};
        end
    end
    assign yc = $signed({1'b0, CW'(p2_r_reg), 16'b0}) - $signed({2'b0, rows_c, 15'b0});

    // stage 3: round to target row and test against last row written
    assign acc = ACCW'(p3_pa_reg) + ACCW'(p3_pb_reg)
               + $signed(ACCW'({rows_c, 30'b0})) + $signed(ACCW'({1'b1, 30'b0}));
    assign nr       = acc[ACCW-1:31];
    assign prev_row = p3_f_reg ? NRW'(-1) : NRW'(lwr_reg);
    assign wk_ok    = p3_v_reg && (nr > prev_row) && !nr[NRW-1] &&
                      (nr < $signed(NRW'({1'b0, rows_c})));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            lwr_reg  <= '1;
        end else begin
            p1_v_reg <= (state_reg == ST_WALK) && wk_act_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (wk_ok) begin
                lwr_reg <= (CW+1)'(nr);
            end else if (p3_v_reg && p3_f_reg) begin
                lwr_reg <= '1;
            end
        end
    end

    // walk payload
    always_ff @(posedge aclk) begin
        p1_r_reg    <= wk_row_reg;
        p1_c_reg    <= wk_col_reg;
        p1_f_reg    <= (wk_row_reg == '0);
        p2_r_reg    <= p1_r_reg;
        p2_c_reg    <= p1_c_reg;
        p2_f_reg    <= p1_f_reg;
        p2_ct_reg   <= src_c;
        p2_diff_reg <= diff_w;
        p2_rel_reg  <= RLW'(diff_w) - RLW'(mean_reg);
        p3_r_reg    <= p2_r_reg;
        p3_c_reg    <= p2_c_reg;
        p3_f_reg    <= p2_f_reg;
        p3_ct_reg   <= p2_ct_reg;
        p3_rel_reg  <= rel_s;
        p3_amin_reg <= amin_s;
        p3_pa_reg   <= yc * cos_reg;
        p3_pb_reg   <= rel_s * sin_reg;
    end

    // tilted store write: clear in sweep, placement in walk
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            t_we    = 1'b1;
            t_waddr = sw_addr_reg;
            t_wdata = '0;
        end else begin
            t_we    = wk_ok;
            t_waddr = {nr[IW-1:0], p3_c_reg};
            t_wdata = {1'b1, 8'(p3_r_reg), p3_amin_reg, p3_ct_reg, p3_rel_reg};
        end
    end
    assign t_raddr = {IW'(mod_dim(s_read_row, MAX_DIM)), IW'(mod_dim(s_read_col, MAX_DIM))};

    always_ff @(posedge aclk) begin
        if (t_we) begin
            tlt_mem[t_waddr] <= t_wdata;
        end
        tlt_q_reg <= tlt_mem[t_raddr];
    end

    // read result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_pend_reg <= rd_acc;
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            o_as_reg <= tlt_q_reg[TW-1];
            if (tlt_q_reg[TW-1]) begin
                o_th_reg <= tlt_q_reg[HB-1:0];
                o_tc_reg <= tlt_q_reg[HB+7:HB];
                o_am_reg <= tlt_q_reg[2*HB+7:HB+8];
                o_sr_reg <= tlt_q_reg[TW-2:2*HB+8];
            end else begin
                o_th_reg <= clear_h_reg;
                o_tc_reg <= '0;
                o_am_reg <= '0;
                o_sr_reg <= '0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_tilted_height    = o_th_reg;
    assign m_tilted_contrast  = o_tc_reg;
    assign m_height_above_min = o_am_reg;
    assign m_assigned         = o_as_reg;
    assign m_source_row       = o_sr_reg;

    // checks
    `HMTR_ASSERT_NOW(a_ready_only_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `HMTR_ASSERT_NXT(a_last_starts_run, aclk, aresetn, ld_acc && s_last, state_reg == ST_SWEEP && run_reg)
    `HMTR_ASSERT_NOW(a_result_from_read, aclk, aresetn, $rose(m_valid_reg), $past(rd_pend_reg))
    `HMTR_ASSERT_NOW(a_write_phase, aclk, aresetn, t_we, state_reg == ST_SWEEP || state_reg == ST_WALK)

endmodule
